// ===== rtl/iems_pkg.sv =====
`timescale 1ns / 1ps

package iems_pkg;

    // Bus primitive codes handed to the bus controller.
    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_START  = 3'd1,
        CMD_SEND   = 3'd2,
        CMD_RSTART = 3'd3,
        CMD_RECV   = 3'd4,
        CMD_ACK    = 3'd5,
        CMD_STOP   = 3'd6
    } cmd_t;

    // Input action codes.
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_SPARE = 2'd3
    } action_t;

    // Kind of job in progress.
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    // Job completion codes.
    typedef enum logic [1:0] {
        END_NONE  = 2'd0,
        END_OK    = 2'd1,
        END_ERROR = 2'd2
    } job_end_t;

    // Sequencer phases.
    typedef enum logic [4:0] {
        PH_IDLE        = 5'd0,
        PH_START       = 5'd1,
        PH_CTRL        = 5'd2,
        PH_CTRL_ACK    = 5'd3,
        PH_ADDR_HI     = 5'd4,
        PH_ADDR_LO     = 5'd5,
        PH_WR_DATA     = 5'd6,
        PH_WR_ACK      = 5'd7,
        PH_RSTART      = 5'd8,
        PH_RD_CTRL     = 5'd9,
        PH_RD_CTRL_ACK = 5'd10,
        PH_RECV        = 5'd11,
        PH_RX_DONE     = 5'd12,
        PH_ACK_DONE    = 5'd13,
        PH_STOP        = 5'd14,
        PH_STOP_WAIT   = 5'd15,
        PH_ERR_STOP    = 5'd16,
        PH_ERR_WAIT    = 5'd17,
        PH_RETRY_STOP  = 5'd18,
        PH_RETRY_WAIT  = 5'd19
    } phase_t;

    // Register indexes of the configuration port.
    localparam logic CFG_TWO_BYTE_ADDRESS = 1'b0;
    localparam logic CFG_RETRY_LIMIT      = 1'b1;

    // Reset value of the held device select byte.
    localparam logic [7:0] SLAVE_RESET = 8'hA0;

    // One input item.
    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  slave_address;
        logic [2:0]  chip_select;
        logic [15:0] mem_address;
        logic [15:0] byte_count;
        logic        bus_done;
        logic        bus_nack;
        logic [7:0]  rx_byte;
        logic [7:0]  write_byte;
    } item_t;

    // One result item.
    typedef struct packed {
        cmd_t        bus_command;
        logic [7:0]  tx_byte;
        logic        ack_level;
        logic [15:0] data_index;
        logic        rx_valid;
        logic [7:0]  rx_data;
        logic        busy_res;
        job_end_t    job_end;
    } result_t;

    // Sequencer state carried from one item to the next.
    typedef struct packed {
        phase_t      phase;
        kind_t       job_kind;
        logic [15:0] byte_counter;
        logic [7:0]  retry_counter;
        logic [7:0]  held_slave;
        logic [2:0]  held_select;
        logic [15:0] held_address;
        logic [15:0] held_length;
    } seq_state_t;

    // Configuration register contents.
    typedef struct packed {
        logic       two_byte_address;
        logic [7:0] retry_limit;
    } cfg_t;

endpackage

// ===== rtl/iems_in_reg.sv =====
`timescale 1ns / 1ps

module iems_in_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  iems_pkg::item_t      s_item,
    output logic                 item_valid,
    output iems_pkg::item_t      item,
    input  logic                 item_take
);

    logic            vld_reg;
    logic            vld_next;
    iems_pkg::item_t item_reg;

    // The register may reload in the same cycle as its content moves on.
    assign s_ready  = !vld_reg || item_take;
    assign vld_next = (s_valid && s_ready) || (vld_reg && !item_take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = vld_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/iems_step.sv =====
`timescale 1ns / 1ps

module iems_step (
    input  iems_pkg::item_t      item,
    input  iems_pkg::seq_state_t st,
    input  iems_pkg::cfg_t       cfg,
    output iems_pkg::seq_state_t st_next,
    output iems_pkg::result_t    res
);

    logic        begin_job;
    logic [15:0] count_inc;
    logic [7:0]  ctrl_base;
    logic [15:0] length_eff;

    // A begin action is only honoured when no job is in progress.
    assign begin_job = (st.job_kind == iems_pkg::KIND_NONE) &&
                       ((item.action == iems_pkg::ACT_WRITE) ||
                        (item.action == iems_pkg::ACT_READ));
    assign count_inc  = st.byte_counter + 16'd1;
    assign ctrl_base  = st.held_slave | {4'd0, st.held_select, 1'b0};
    assign length_eff = (item.byte_count == 16'd0) ? 16'd1 : item.byte_count;

    // Next state.
    always_comb begin
        st_next = st;
        if (begin_job) begin
            st_next.job_kind      = (item.action == iems_pkg::ACT_WRITE) ?
                                    iems_pkg::KIND_WRITE : iems_pkg::KIND_READ;
            st_next.held_slave    = item.slave_address;
            st_next.held_select   = item.chip_select;
            st_next.held_address  = item.mem_address;
            st_next.held_length   = length_eff;
            st_next.byte_counter  = 16'd0;
            st_next.retry_counter = 8'd0;
            st_next.phase         = iems_pkg::PH_IDLE;
        end else begin
            case (st.phase)
                iems_pkg::PH_IDLE: begin
                    if (st.job_kind != iems_pkg::KIND_NONE) begin
                        st_next.phase = iems_pkg::PH_START;
                    end
                end
                iems_pkg::PH_START: begin
                    st_next.phase = iems_pkg::PH_CTRL;
                end
                iems_pkg::PH_CTRL: begin
                    if (item.bus_done) begin
                        st_next.phase = iems_pkg::PH_CTRL_ACK;
                    end
                end
                iems_pkg::PH_CTRL_ACK: begin
                    if (item.bus_done) begin
                        if (item.bus_nack) begin
                            st_next.phase = (st.retry_counter < cfg.retry_limit) ?
                                            iems_pkg::PH_RETRY_STOP :
                                            iems_pkg::PH_ERR_STOP;
                        end else begin
                            st_next.retry_counter = 8'd0;
                            st_next.phase = cfg.two_byte_address ?
                                            iems_pkg::PH_ADDR_HI : iems_pkg::PH_ADDR_LO;
                        end
                    end
                end
                iems_pkg::PH_ADDR_HI: begin
                    if (item.bus_done) begin
                        st_next.phase = item.bus_nack ?
                                        iems_pkg::PH_ERR_STOP : iems_pkg::PH_ADDR_LO;
                    end
                end
                iems_pkg::PH_ADDR_LO: begin
                    if (item.bus_done) begin
                        if (item.bus_nack) begin
                            st_next.phase = iems_pkg::PH_ERR_STOP;
                        end else if (st.job_kind == iems_pkg::KIND_WRITE) begin
                            st_next.phase = iems_pkg::PH_WR_DATA;
                        end else begin
                            st_next.phase = iems_pkg::PH_RSTART;
                        end
                    end
                end
                iems_pkg::PH_WR_DATA: begin
                    st_next.byte_counter = count_inc;
                    st_next.phase        = iems_pkg::PH_WR_ACK;
                end
                iems_pkg::PH_WR_ACK: begin
                    if (item.bus_done) begin
                        if (item.bus_nack) begin
                            st_next.phase = iems_pkg::PH_ERR_STOP;
                        end else if (st.byte_counter == st.held_length) begin
                            st_next.phase = iems_pkg::PH_STOP;
                        end else begin
                            st_next.phase = iems_pkg::PH_WR_DATA;
                        end
                    end
                end
                iems_pkg::PH_RSTART: begin
                    st_next.phase = iems_pkg::PH_RD_CTRL;
                end
                iems_pkg::PH_RD_CTRL: begin
                    if (item.bus_done) begin
                        st_next.phase = iems_pkg::PH_RD_CTRL_ACK;
                    end
                end
                iems_pkg::PH_RD_CTRL_ACK: begin
                    if (item.bus_done) begin
                        st_next.phase = item.bus_nack ?
                                        iems_pkg::PH_ERR_STOP : iems_pkg::PH_RECV;
                    end
                end
                iems_pkg::PH_RECV: begin
                    st_next.phase = iems_pkg::PH_RX_DONE;
                end
                iems_pkg::PH_RX_DONE: begin
                    if (item.bus_done) begin
                        st_next.byte_counter = count_inc;
                        st_next.phase        = iems_pkg::PH_ACK_DONE;
                    end
                end
                iems_pkg::PH_ACK_DONE: begin
                    if (item.bus_done) begin
                        st_next.phase = (st.byte_counter == st.held_length) ?
                                        iems_pkg::PH_STOP : iems_pkg::PH_RECV;
                    end
                end
                iems_pkg::PH_STOP: begin
                    st_next.phase = iems_pkg::PH_STOP_WAIT;
                end
                iems_pkg::PH_ERR_STOP: begin
                    st_next.phase = iems_pkg::PH_ERR_WAIT;
                end
                iems_pkg::PH_RETRY_STOP: begin
                    st_next.retry_counter = st.retry_counter + 8'd1;
                    st_next.phase         = iems_pkg::PH_RETRY_WAIT;
                end
                iems_pkg::PH_RETRY_WAIT: begin
                    if (item.bus_done) begin
                        st_next.phase        = iems_pkg::PH_IDLE;
                        st_next.byte_counter = 16'd0;
                    end
                end
                iems_pkg::PH_STOP_WAIT, iems_pkg::PH_ERR_WAIT: begin
                    if (item.bus_done) begin
                        st_next.phase         = iems_pkg::PH_IDLE;
                        st_next.job_kind      = iems_pkg::KIND_NONE;
                        st_next.byte_counter  = 16'd0;
                        st_next.retry_counter = 8'd0;
                    end
                end
                default: begin
                    // An unused phase code drops back to idle with no job.
                    st_next.phase         = iems_pkg::PH_IDLE;
                    st_next.job_kind      = iems_pkg::KIND_NONE;
                    st_next.byte_counter  = 16'd0;
                    st_next.retry_counter = 8'd0;
                end
            endcase
        end
    end

    // Result fields.
    always_comb begin
        res             = '0;
        res.bus_command = iems_pkg::CMD_NONE;
        res.job_end     = iems_pkg::END_NONE;
        if (!begin_job) begin
            case (st.phase)
                iems_pkg::PH_START: begin
                    res.bus_command = iems_pkg::CMD_START;
                end
                iems_pkg::PH_CTRL: begin
                    if (item.bus_done) begin
                        res.bus_command = iems_pkg::CMD_SEND;
                        res.tx_byte     = ctrl_base;
                    end
                end
                iems_pkg::PH_CTRL_ACK: begin
                    if (item.bus_done && !item.bus_nack) begin
                        res.bus_command = iems_pkg::CMD_SEND;
                        res.tx_byte     = cfg.two_byte_address ?
                                          st.held_address[15:8] : st.held_address[7:0];
                    end
                end
                iems_pkg::PH_ADDR_HI: begin
                    if (item.bus_done && !item.bus_nack) begin
                        res.bus_command = iems_pkg::CMD_SEND;
                        res.tx_byte     = st.held_address[7:0];
                    end
                end
                iems_pkg::PH_WR_DATA: begin
                    res.bus_command = iems_pkg::CMD_SEND;
                    res.tx_byte     = item.write_byte;
                    res.data_index  = st.byte_counter;
                end
                iems_pkg::PH_RSTART: begin
                    res.bus_command = iems_pkg::CMD_RSTART;
                end
                iems_pkg::PH_RD_CTRL: begin
                    if (item.bus_done) begin
                        res.bus_command = iems_pkg::CMD_SEND;
                        res.tx_byte     = ctrl_base | 8'd1;
                    end
                end
                iems_pkg::PH_RECV: begin
                    res.bus_command = iems_pkg::CMD_RECV;
                end
                iems_pkg::PH_RX_DONE: begin
                    if (item.bus_done) begin
                        res.bus_command = iems_pkg::CMD_ACK;
                        res.rx_valid    = 1'b1;
                        res.rx_data     = item.rx_byte;
                        res.data_index  = st.byte_counter;
                        res.ack_level   = (count_inc == st.held_length);
                    end
                end
                iems_pkg::PH_STOP, iems_pkg::PH_ERR_STOP, iems_pkg::PH_RETRY_STOP: begin
                    res.bus_command = iems_pkg::CMD_STOP;
                end
                iems_pkg::PH_STOP_WAIT: begin
                    if (item.bus_done) begin
                        res.job_end = iems_pkg::END_OK;
                    end
                end
                iems_pkg::PH_ERR_WAIT: begin
                    if (item.bus_done) begin
                        res.job_end = iems_pkg::END_ERROR;
                    end
                end
                default: begin
                    res.bus_command = iems_pkg::CMD_NONE;
                end
            endcase
        end
        res.busy_res = (st_next.job_kind != iems_pkg::KIND_NONE);
    end

endmodule

// ===== rtl/i2c_eeprom_master_sequencer_unit.sv =====
`timescale 1ns / 1ps

// I2C EEPROM random read / write sequencer.
// The input channel (s_*) carries one clock tick of the bus controller per
// transaction: either a plain tick with the bus_done / bus_nack / rx_byte /
// write_byte responses, or a begin action that latches a write or read job.
// Every accepted input transaction yields exactly one result transaction on
// the m_* channel, naming the next bus primitive, any received byte with its
// index, the busy flag and the job completion code.
// The item is captured in an input register, then one pass of the phase logic
// updates the sequencer state and loads the output register, whose content is
// presented on m_*. Throughput is one transaction per cycle while m_ready is
// high; the only loop is the phase and counter update between the input and
// output registers.
// When the receiver holds m_ready low, the output register keeps its result,
// the input register holds the next item and s_ready falls once both are full.
// Reset (aresetn low at a clock edge) empties both registers, returns the
// sequencer to idle with no job, and sets two_byte_address to 1 and
// retry_limit to 3. Configuration writes take effect at once and are meant
// for times when no job is in flight.
module i2c_eeprom_master_sequencer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_slave_address,
    input  logic [2:0]  s_chip_select,
    input  logic [15:0] s_mem_address,
    input  logic [15:0] s_byte_count,
    input  logic        s_bus_done,
    input  logic        s_bus_nack,
    input  logic [7:0]  s_rx_byte,
    input  logic [7:0]  s_write_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_bus_command,
    output logic [7:0]  m_tx_byte,
    output logic        m_ack_level,
    output logic [15:0] m_data_index,
    output logic        m_rx_valid,
    output logic [7:0]  m_rx_data,
    output logic        m_busy_res,
    output logic [1:0]  m_job_end,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata
);

    iems_pkg::item_t      s_item;
    iems_pkg::item_t      item;
    logic                 item_valid;
    logic                 step_go;
    iems_pkg::seq_state_t st_reg;
    iems_pkg::seq_state_t st_next;
    iems_pkg::cfg_t       cfg_reg;
    iems_pkg::result_t    res_next;
    iems_pkg::result_t    res_reg;
    logic                 m_valid_reg;
    logic                 m_valid_next;

    assign s_item.action        = s_action;
    assign s_item.slave_address = s_slave_address;
    assign s_item.chip_select   = s_chip_select;
    assign s_item.mem_address   = s_mem_address;
    assign s_item.byte_count    = s_byte_count;
    assign s_item.bus_done      = s_bus_done;
    assign s_item.bus_nack      = s_bus_nack;
    assign s_item.rx_byte       = s_rx_byte;
    assign s_item.write_byte    = s_write_byte;

    // Input register.
    iems_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (step_go)
    );

    // Phase logic for one tick.
    iems_step u_step (
        .item    (item),
        .st      (st_reg),
        .cfg     (cfg_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // The step fires when an item waits and the output register is free or being emptied.
    assign step_go      = item_valid && (!m_valid_reg || m_ready);
    assign m_valid_next = step_go || (m_valid_reg && !m_ready);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.two_byte_address <= 1'b1;
            cfg_reg.retry_limit      <= 8'd3;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                iems_pkg::CFG_TWO_BYTE_ADDRESS: cfg_reg.two_byte_address <= cfg_wdata[0];
                iems_pkg::CFG_RETRY_LIMIT:      cfg_reg.retry_limit      <= cfg_wdata;
                default:                        cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase         <= iems_pkg::PH_IDLE;
            st_reg.job_kind      <= iems_pkg::KIND_NONE;
            st_reg.byte_counter  <= 16'd0;
            st_reg.retry_counter <= 8'd0;
            st_reg.held_slave    <= iems_pkg::SLAVE_RESET;
            st_reg.held_select   <= 3'd0;
            st_reg.held_address  <= 16'd0;
            st_reg.held_length   <= 16'd0;
        end else if (step_go) begin
            st_reg <= st_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (step_go) begin
            res_reg <= res_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_bus_command = res_reg.bus_command;
    assign m_tx_byte     = res_reg.tx_byte;
    assign m_ack_level   = res_reg.ack_level;
    assign m_data_index  = res_reg.data_index;
    assign m_rx_valid    = res_reg.rx_valid;
    assign m_rx_data     = res_reg.rx_data;
    assign m_busy_res    = res_reg.busy_res;
    assign m_job_end     = res_reg.job_end;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 370;
    localparam int NUM_PHASES  = 5;

    // Clock, reset and block ports, every driven input at a known value from time zero.
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = '0;
    logic [7:0]  s_slave_address = '0;
    logic [2:0]  s_chip_select = '0;
    logic [15:0] s_mem_address = '0;
    logic [15:0] s_byte_count = '0;
    logic        s_bus_done = 1'b0;
    logic        s_bus_nack = 1'b0;
    logic [7:0]  s_rx_byte = '0;
    logic [7:0]  s_write_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_bus_command;
    logic [7:0]  m_tx_byte;
    logic        m_ack_level;
    logic [15:0] m_data_index;
    logic        m_rx_valid;
    logic [7:0]  m_rx_data;
    logic        m_busy_res;
    logic [1:0]  m_job_end;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_wdata = '0;

    // Shadow copy of the sequencer and its registers.
    logic              wide_addr;
    logic [7:0]        retry_cap;
    iems_pkg::phase_t  seq_phase;
    iems_pkg::kind_t   seq_kind;
    logic [15:0]       seq_count;
    logic [7:0]        seq_retries;
    logic [7:0]        seq_slave;
    logic [2:0]        seq_select;
    logic [15:0]       seq_addr;
    logic [15:0]       seq_length;

    // Bus primitives still owed by the block, oldest first.
    iems_pkg::result_t pending_primitives[$];
    int unsigned       fault_count = 0;
    int unsigned       quiet_cycles = 0;
    bit                calm = 1'b0;

    typedef struct {
        iems_pkg::item_t   stim;
        bit                typed;
        iems_pkg::result_t want;
    } stim_row_t;

    stim_row_t opening_rows[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    i2c_eeprom_master_sequencer_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_slave_address (s_slave_address),
        .s_chip_select   (s_chip_select),
        .s_mem_address   (s_mem_address),
        .s_byte_count    (s_byte_count),
        .s_bus_done      (s_bus_done),
        .s_bus_nack      (s_bus_nack),
        .s_rx_byte       (s_rx_byte),
        .s_write_byte    (s_write_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_bus_command   (m_bus_command),
        .m_tx_byte       (m_tx_byte),
        .m_ack_level     (m_ack_level),
        .m_data_index    (m_data_index),
        .m_rx_valid      (m_rx_valid),
        .m_rx_data       (m_rx_data),
        .m_busy_res      (m_busy_res),
        .m_job_end       (m_job_end),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    // Control byte as the sequencer builds it from the held job fields.
    function automatic logic [7:0] device_select(input logic rw);
        return seq_slave | {7'd0, rw} | {4'd0, seq_select, 1'b0};
    endfunction

    function automatic void close_job();
        seq_phase   = iems_pkg::PH_IDLE;
        seq_kind    = iems_pkg::KIND_NONE;
        seq_count   = '0;
        seq_retries = '0;
    endfunction

    // Advances the shadow sequencer by one tick and returns the primitive it issues.
    function automatic iems_pkg::result_t next_bus_primitive(input iems_pkg::item_t it);
        iems_pkg::result_t r;
        r = '0;
        if (seq_kind == iems_pkg::KIND_NONE &&
            (it.action == iems_pkg::ACT_WRITE || it.action == iems_pkg::ACT_READ)) begin
            seq_kind    = (it.action == iems_pkg::ACT_WRITE) ?
                          iems_pkg::KIND_WRITE : iems_pkg::KIND_READ;
            seq_slave   = it.slave_address;
            seq_select  = it.chip_select;
            seq_addr    = it.mem_address;
            seq_length  = (it.byte_count == 16'd0) ? 16'd1 : it.byte_count;
            seq_count   = '0;
            seq_retries = '0;
            seq_phase   = iems_pkg::PH_IDLE;
        end else begin
            case (seq_phase)
                iems_pkg::PH_IDLE: begin
                    if (seq_kind != iems_pkg::KIND_NONE) seq_phase = iems_pkg::PH_START;
                end
                iems_pkg::PH_START: begin
                    r.bus_command = iems_pkg::CMD_START;
                    seq_phase = iems_pkg::PH_CTRL;
                end
                iems_pkg::PH_CTRL: begin
                    if (it.bus_done) begin
                        r.bus_command = iems_pkg::CMD_SEND;
                        r.tx_byte = device_select(1'b0);
                        seq_phase = iems_pkg::PH_CTRL_ACK;
                    end
                end
                iems_pkg::PH_CTRL_ACK: begin
                    if (it.bus_done) begin
                        if (it.bus_nack) begin
                            seq_phase = (seq_retries < retry_cap) ?
                                        iems_pkg::PH_RETRY_STOP : iems_pkg::PH_ERR_STOP;
                        end else begin
                            seq_retries = '0;
                            r.bus_command = iems_pkg::CMD_SEND;
                            if (wide_addr) begin
                                r.tx_byte = seq_addr[15:8];
                                seq_phase = iems_pkg::PH_ADDR_HI;
                            end else begin
                                r.tx_byte = seq_addr[7:0];
                                seq_phase = iems_pkg::PH_ADDR_LO;
                            end
                        end
                    end
                end
                iems_pkg::PH_ADDR_HI: begin
                    if (it.bus_done) begin
                        if (it.bus_nack) begin
                            seq_phase = iems_pkg::PH_ERR_STOP;
                        end else begin
                            r.bus_command = iems_pkg::CMD_SEND;
                            r.tx_byte = seq_addr[7:0];
                            seq_phase = iems_pkg::PH_ADDR_LO;
                        end
                    end
                end
                iems_pkg::PH_ADDR_LO: begin
                    if (it.bus_done) begin
                        if (it.bus_nack) seq_phase = iems_pkg::PH_ERR_STOP;
                        else seq_phase = (seq_kind == iems_pkg::KIND_WRITE) ?
                                         iems_pkg::PH_WR_DATA : iems_pkg::PH_RSTART;
                    end
                end
                iems_pkg::PH_WR_DATA: begin
                    r.bus_command = iems_pkg::CMD_SEND;
                    r.tx_byte = it.write_byte;
                    r.data_index = seq_count;
                    seq_count = seq_count + 16'd1;
                    seq_phase = iems_pkg::PH_WR_ACK;
                end
                iems_pkg::PH_WR_ACK: begin
                    if (it.bus_done) begin
                        if (it.bus_nack) seq_phase = iems_pkg::PH_ERR_STOP;
                        else seq_phase = (seq_count == seq_length) ?
                                         iems_pkg::PH_STOP : iems_pkg::PH_WR_DATA;
                    end
                end
                iems_pkg::PH_RSTART: begin
                    r.bus_command = iems_pkg::CMD_RSTART;
                    seq_phase = iems_pkg::PH_RD_CTRL;
                end
                iems_pkg::PH_RD_CTRL: begin
                    if (it.bus_done) begin
                        r.bus_command = iems_pkg::CMD_SEND;
                        r.tx_byte = device_select(1'b1);
                        seq_phase = iems_pkg::PH_RD_CTRL_ACK;
                    end
                end
                iems_pkg::PH_RD_CTRL_ACK: begin
                    if (it.bus_done) seq_phase = it.bus_nack ?
                                                 iems_pkg::PH_ERR_STOP : iems_pkg::PH_RECV;
                end
                iems_pkg::PH_RECV: begin
                    r.bus_command = iems_pkg::CMD_RECV;
                    seq_phase = iems_pkg::PH_RX_DONE;
                end
                iems_pkg::PH_RX_DONE: begin
                    if (it.bus_done) begin
                        r.rx_valid = 1'b1;
                        r.rx_data = it.rx_byte;
                        r.data_index = seq_count;
                        seq_count = seq_count + 16'd1;
                        r.bus_command = iems_pkg::CMD_ACK;
                        r.ack_level = (seq_count == seq_length);
                        seq_phase = iems_pkg::PH_ACK_DONE;
                    end
                end
                iems_pkg::PH_ACK_DONE: begin
                    if (it.bus_done) seq_phase = (seq_count == seq_length) ?
                                                 iems_pkg::PH_STOP : iems_pkg::PH_RECV;
                end
                iems_pkg::PH_STOP: begin
                    r.bus_command = iems_pkg::CMD_STOP;
                    seq_phase = iems_pkg::PH_STOP_WAIT;
                end
                iems_pkg::PH_STOP_WAIT: begin
                    if (it.bus_done) begin
                        close_job();
                        r.job_end = iems_pkg::END_OK;
                    end
                end
                iems_pkg::PH_ERR_STOP: begin
                    r.bus_command = iems_pkg::CMD_STOP;
                    seq_phase = iems_pkg::PH_ERR_WAIT;
                end
                iems_pkg::PH_ERR_WAIT: begin
                    if (it.bus_done) begin
                        close_job();
                        r.job_end = iems_pkg::END_ERROR;
                    end
                end
                iems_pkg::PH_RETRY_STOP: begin
                    r.bus_command = iems_pkg::CMD_STOP;
                    seq_phase = iems_pkg::PH_RETRY_WAIT;
                    seq_retries = seq_retries + 8'd1;
                end
                iems_pkg::PH_RETRY_WAIT: begin
                    if (it.bus_done) begin
                        seq_phase = iems_pkg::PH_IDLE;
                        seq_count = '0;
                    end
                end
                default: begin
                    close_job();
                end
            endcase
        end
        r.busy_res = (seq_kind != iems_pkg::KIND_NONE);
        return r;
    endfunction

    // Random tick shaped by where the shadow sequencer stands, so that most
    // jobs run to completion and long jobs are cut short by a NACK.
    function automatic iems_pkg::item_t draw_bus_tick();
        iems_pkg::item_t it;
        int unsigned     roll;
        int unsigned     nack_pct;
        bit              long_job;
        roll = $urandom_range(0, 99);
        it.slave_address = 8'($urandom_range(0, 254));
        it.chip_select   = 3'($urandom_range(0, 7));
        it.mem_address   = 16'($urandom_range(0, 65535));
        it.byte_count    = (roll < 55) ? 16'($urandom_range(0, 4)) :
                           (roll < 90) ? 16'($urandom_range(5, 20)) :
                                         16'($urandom_range(0, 65535));
        it.rx_byte       = 8'($urandom_range(0, 255));
        it.write_byte    = 8'($urandom_range(0, 255));
        it.bus_done      = ($urandom_range(0, 99) < 75);
        long_job = (seq_length > 16'd24);
        nack_pct = 5;
        case (seq_phase)
            iems_pkg::PH_CTRL_ACK: nack_pct = 30;
            iems_pkg::PH_ADDR_LO: if (long_job) nack_pct = 70;
            iems_pkg::PH_WR_ACK: if (long_job) nack_pct = 30;
            iems_pkg::PH_RD_CTRL_ACK: if (long_job) nack_pct = 100;
            default: ;
        endcase
        it.bus_nack = ($urandom_range(0, 99) < nack_pct);
        roll = $urandom_range(0, 99);
        if (seq_kind == iems_pkg::KIND_NONE) begin
            if (roll < 85) it.action = $urandom_range(0, 1) ?
                                       iems_pkg::ACT_WRITE : iems_pkg::ACT_READ;
            else if (roll < 95) it.action = iems_pkg::ACT_TICK;
            else it.action = iems_pkg::ACT_SPARE;
        end else begin
            if (roll < 90) it.action = iems_pkg::ACT_TICK;
            else if (roll < 95) it.action = $urandom_range(0, 1) ?
                                            iems_pkg::ACT_WRITE : iems_pkg::ACT_READ;
            else it.action = iems_pkg::ACT_SPARE;
        end
        return it;
    endfunction

    function automatic iems_pkg::item_t tick_item(input logic done, input logic nack,
                                                  input logic [7:0] wbyte);
        iems_pkg::item_t it;
        it = '0;
        it.action     = iems_pkg::ACT_TICK;
        it.bus_done   = done;
        it.bus_nack   = nack;
        it.write_byte = wbyte;
        return it;
    endfunction

    function automatic iems_pkg::item_t begin_item(input iems_pkg::action_t act,
                                                   input logic [7:0] slave,
                                                   input logic [2:0] sel,
                                                   input logic [15:0] addr,
                                                   input logic [15:0] count);
        iems_pkg::item_t it;
        it = '0;
        it.action        = act;
        it.slave_address = slave;
        it.chip_select   = sel;
        it.mem_address   = addr;
        it.byte_count    = count;
        return it;
    endfunction

    function automatic iems_pkg::result_t prim(input iems_pkg::cmd_t cmd,
                                               input logic [7:0] tx,
                                               input logic [15:0] idx, input logic busy,
                                               input iems_pkg::job_end_t fin);
        iems_pkg::result_t r;
        r = '0;
        r.bus_command = cmd;
        r.tx_byte     = tx;
        r.data_index  = idx;
        r.busy_res    = busy;
        r.job_end     = fin;
        return r;
    endfunction

    function automatic string describe(input iems_pkg::result_t r);
        return $sformatf("cmd=%0d tx=%02h ack=%0d idx=%0d rxv=%0d rxd=%02h busy=%0d end=%0d",
                         r.bus_command, r.tx_byte, r.ack_level, r.data_index,
                         r.rx_valid, r.rx_data, r.busy_res, r.job_end);
    endfunction

    // Presents one transaction, holding it until accepted, and records what it should yield.
    // Entered and left just after a falling edge.
    task automatic send_item(input iems_pkg::item_t it, input bit typed,
                             input iems_pkg::result_t want);
        iems_pkg::result_t predicted;
        while (!calm && $urandom_range(0, 99) < 35) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_action        <= it.action;
        s_slave_address <= it.slave_address;
        s_chip_select   <= it.chip_select;
        s_mem_address   <= it.mem_address;
        s_byte_count    <= it.byte_count;
        s_bus_done      <= it.bus_done;
        s_bus_nack      <= it.bus_nack;
        s_rx_byte       <= it.rx_byte;
        s_write_byte    <= it.write_byte;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted = next_bus_primitive(it);
        pending_primitives.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == iems_pkg::CFG_TWO_BYTE_ADDRESS) wide_addr = val[0];
        else retry_cap = val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Stops sending until every owed primitive has come back, then lets the block settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_primitives.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Receiver back-pressure.
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 35);
    end

    // Result checker.
    always @(posedge aclk) begin
        iems_pkg::result_t seen;
        iems_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = {m_bus_command, m_tx_byte, m_ack_level, m_data_index,
                    m_rx_valid, m_rx_data, m_busy_res, m_job_end};
            if (pending_primitives.size() == 0) begin
                if (fault_count < 10) $display("unexpected result: %s", describe(seen));
                fault_count++;
            end else begin
                want = pending_primitives.pop_front();
                if (seen !== want) begin
                    if (fault_count < 10) begin
                        $display("mismatch: expected %s", describe(want));
                        $display("          actual   %s", describe(seen));
                    end
                    fault_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    bit         phase_wide[NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic [7:0] phase_cap[NUM_PHASES]  = '{8'd3, 8'd0, 8'd255, 8'd1, 8'd2};

    initial begin
        int unsigned sent;
        wide_addr   = 1'b1;
        retry_cap   = 8'd3;
        seq_slave   = iems_pkg::SLAVE_RESET;
        seq_select  = '0;
        seq_addr    = '0;
        seq_length  = '0;
        close_job();

        // Full write job at the field extremes with a zero length, then a read
        // job that is restarted once on a control byte NACK and then aborted on
        // an address NACK, with a spare action and a begin while busy on the way.
        opening_rows.push_back('{tick_item(0, 0, 8'h00), 1,
                                 prim(iems_pkg::CMD_NONE, 0, 0, 0, iems_pkg::END_NONE)});
        opening_rows.push_back('{begin_item(iems_pkg::ACT_WRITE, 8'hFE, 3'd7, 16'hFFFF,
                                            16'h0000), 1,
                                 prim(iems_pkg::CMD_NONE, 0, 0, 1, iems_pkg::END_NONE)});
        opening_rows.push_back('{tick_item(0, 0, 8'h00), 1,
                                 prim(iems_pkg::CMD_NONE, 0, 0, 1, iems_pkg::END_NONE)});
        opening_rows.push_back('{tick_item(0, 0, 8'h00), 1,
                                 prim(iems_pkg::CMD_START, 0, 0, 1, iems_pkg::END_NONE)});
        opening_rows.push_back('{tick_item(1, 0, 8'h00), 1,
                                 prim(iems_pkg::CMD_SEND, 8'hFE, 0, 1, iems_pkg::END_NONE)});
        opening_rows.push_back('{tick_item(1, 0, 8'h00), 1,
                                 prim(iems_pkg::CMD_SEND, 8'hFF, 0, 1, iems_pkg::END_NONE)});
        opening_rows.push_back('{tick_item(1, 0, 8'h00), 1,
                                 prim(iems_pkg::CMD_SEND, 8'hFF, 0, 1, iems_pkg::END_NONE)});
        opening_rows.push_back('{tick_item(1, 0, 8'h00), 1,
                                 prim(iems_pkg::CMD_NONE, 0, 0, 1, iems_pkg::END_NONE)});
        opening_rows.push_back('{tick_item(0, 0, 8'hFF), 1,
                                 prim(iems_pkg::CMD_SEND, 8'hFF, 0, 1, iems_pkg::END_NONE)});
        opening_rows.push_back('{tick_item(1, 0, 8'h00), 1,
                                 prim(iems_pkg::CMD_NONE, 0, 0, 1, iems_pkg::END_NONE)});
        opening_rows.push_back('{tick_item(0, 0, 8'h00), 1,
                                 prim(iems_pkg::CMD_STOP, 0, 0, 1, iems_pkg::END_NONE)});
        opening_rows.push_back('{tick_item(1, 0, 8'h00), 1,
                                 prim(iems_pkg::CMD_NONE, 0, 0, 0, iems_pkg::END_OK)});
        opening_rows.push_back('{begin_item(iems_pkg::ACT_READ, 8'h00, 3'd0, 16'h0000,
                                            16'hFFFF), 1,
                                 prim(iems_pkg::CMD_NONE, 0, 0, 1, iems_pkg::END_NONE)});
        opening_rows.push_back('{begin_item(iems_pkg::ACT_SPARE, 8'h00, 3'd0, 16'h0000,
                                            16'h0000), 0, '0});
        opening_rows.push_back('{tick_item(0, 0, 8'h00), 0, '0});
        opening_rows.push_back('{tick_item(1, 0, 8'h00), 0, '0});
        opening_rows.push_back('{tick_item(1, 1, 8'h00), 0, '0});
        opening_rows.push_back('{tick_item(0, 0, 8'h00), 0, '0});
        opening_rows.push_back('{tick_item(1, 0, 8'h00), 0, '0});
        opening_rows.push_back('{begin_item(iems_pkg::ACT_WRITE, 8'h5A, 3'd2, 16'h1234,
                                            16'h0003), 0, '0});
        opening_rows.push_back('{tick_item(0, 0, 8'h00), 0, '0});
        opening_rows.push_back('{tick_item(1, 0, 8'h00), 0, '0});
        opening_rows.push_back('{tick_item(1, 0, 8'h00), 0, '0});
        opening_rows.push_back('{tick_item(1, 1, 8'h00), 0, '0});
        opening_rows.push_back('{tick_item(0, 0, 8'h00), 0, '0});
        opening_rows.push_back('{tick_item(1, 0, 8'h00), 1,
                                 prim(iems_pkg::CMD_NONE, 0, 0, 0, iems_pkg::END_ERROR)});

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (opening_rows[i])
            send_item(opening_rows[i].stim, opening_rows[i].typed, opening_rows[i].want);

        // Random jobs under each register setting; every phase ends with no job open.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                drain();
                write_reg(iems_pkg::CFG_TWO_BYTE_ADDRESS, {7'd0, phase_wide[p]});
                write_reg(iems_pkg::CFG_RETRY_LIMIT, phase_cap[p]);
            end
            calm = (p == 2);
            sent = 0;
            while (sent < PHASE_ITEMS || seq_kind != iems_pkg::KIND_NONE) begin
                send_item(draw_bus_tick(), 1'b0, '0);
                sent++;
            end
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (pending_primitives.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fault_count == 0 && pending_primitives.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
